/* rtl/line_follow_drive_pwm_top_macros.svh */
// Assertion macros shared by the line follower drive checkers.
// No dependencies; taken in by `include where assertions are written.
`ifndef LINE_FOLLOW_DRIVE_PWM_TOP_MACROS_SVH
`define LINE_FOLLOW_DRIVE_PWM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define LFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lfd_pkg.sv */
// Shared types, codes and constants of the line follower drive controller.
// No dependencies; imported by every module of the block.
package lfd_pkg;

	// Widths
	localparam int CNT_W   = 11;  // period counter and internal duty
	localparam int SPD_W   = 13;  // signed wheel speed
	localparam int BASE_W  = 10;
	localparam int TRIM_W  = 9;
	localparam int CFG_W   = 10;
	localparam int DUTY_OUT_W = 10;

	// Defaults for the top-level parameters
	localparam int PWM_PERIOD_DEF = 1000;
	localparam int DUTY_LIMIT_DEF = 1000;

	// Register reset values
	localparam logic [BASE_W-1:0] BASE_RESET = 10'd500;

	// Item kinds
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_LINE = 2'd1;
	localparam logic [1:0] KIND_CMD  = 2'd2;

	// Command codes
	localparam logic [2:0] CMD_UP    = 3'd0;
	localparam logic [2:0] CMD_DOWN  = 3'd1;
	localparam logic [2:0] CMD_LEFT  = 3'd2;
	localparam logic [2:0] CMD_RIGHT = 3'd3;
	localparam logic [2:0] CMD_STOP  = 3'd4;
	localparam logic [2:0] CMD_MODE  = 3'd5;

	// Line patterns, left/mid/right
	localparam logic [2:0] PAT_MID     = 3'b010;
	localparam logic [2:0] PAT_RIGHT   = 3'b001;
	localparam logic [2:0] PAT_MID_RGT = 3'b011;
	localparam logic [2:0] PAT_LEFT    = 3'b100;
	localparam logic [2:0] PAT_LFT_MID = 3'b110;

	// Configuration register indexes
	localparam logic REG_BASE_SPEED = 1'b0;
	localparam logic REG_WHEEL_TRIM = 1'b1;

	// Steering offsets
	localparam int OFS_TURN   = 150;
	localparam int OFS_TRACE  = 100;
	localparam int OFS_HARD_R = 500;
	localparam int OFS_SOFT   = 300;
	localparam int OFS_HARD_L = 600;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_DRIVE,
		OP_TRACE,
		OP_MODE
	} op_t;

	typedef enum logic [3:0] {
		ST_FWD,
		ST_REV,
		ST_LEFT,
		ST_RIGHT,
		ST_STOP,
		ST_CENTER,
		ST_R_HARD,
		ST_R_SOFT,
		ST_L_HARD,
		ST_L_SOFT,
		ST_LOST
	} steer_t;

	typedef enum logic [1:0] {
		DIR_STOP,
		DIR_FWD,
		DIR_REV
	} dir_t;

	typedef enum logic [1:0] {
		DRV_MANUAL,
		DRV_TRACE,
		DRV_AVOID
	} drive_t;

	typedef enum logic [1:0] {
		SIDE_NONE,
		SIDE_RIGHT,
		SIDE_LEFT
	} side_t;

	// One classified request as it travels through the queue
	typedef struct packed {
		op_t    op;
		steer_t steer;
		logic   side_wr;
		side_t  side;
	} item_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

	// Direction and saturated magnitude of one wheel
	typedef struct packed {
		dir_t             dir;
		logic [CNT_W-1:0] duty;
	} wheel_t;

endpackage

/* rtl/line_follow_drive_pwm_top.sv */
// Top level of the two-wheel line follower drive controller with software PWM.
// Depends on lfd_pkg, lfd_front, lfd_queue and lfd_back.
//
//   channel  signals                                      direction
//   in       in_valid/in_stall, mode, line_*, command     request in
//   out      out_valid/out_stall, pwm_*, dir_*, duty_*,   result out
//            drive_state
//   cfg      cfg_we, cfg_index, cfg_data                  register write
//
// One request per clock sustained while out_stall is low; a result is registered in the back end
// after the request has passed through the queue register.
// The back end updates all drive state at once on each request it pops.
// A two-entry queue separates classification from execution; in_stall rises only
// when it is full, which happens only while out_stall holds a result.
// Reset clears all state but the queue slots; base_speed resets to 500 and wheel_trim to 0.
module line_follow_drive_pwm_top
	import lfd_pkg::*;
#(
	parameter int PWM_PERIOD = PWM_PERIOD_DEF,
	parameter int DUTY_LIMIT = DUTY_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic                  line_left,
	input  logic                  line_mid,
	input  logic                  line_right,
	input  logic [2:0]            command,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  pwm_left,
	output logic                  pwm_right,
	output logic [1:0]            dir_left,
	output logic [1:0]            dir_right,
	output logic [DUTY_OUT_W-1:0] duty_left,
	output logic [DUTY_OUT_W-1:0] duty_right,
	output logic [1:0]            drive_state,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	item_t   push_item;
	item_t   head;

	// Accept and classify
	lfd_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.line_left  (line_left),
		.line_mid   (line_mid),
		.line_right (line_right),
		.command    (command),
		.q_stat     (q_stat),
		.push       (push),
		.item       (push_item)
	);

	// Decouple front and back
	lfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_stat    (q_stat),
		.head      (head)
	);

	// Execute and present the result
	lfd_back #(
		.PWM_PERIOD (PWM_PERIOD),
		.DUTY_LIMIT (DUTY_LIMIT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.head        (head),
		.pop         (pop),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pwm_left    (pwm_left),
		.pwm_right   (pwm_right),
		.dir_left    (dir_left),
		.dir_right   (dir_right),
		.duty_left   (duty_left),
		.duty_right  (duty_right),
		.drive_state (drive_state)
	);

endmodule

/* rtl/lfd_front.sv */
// Front end: accepts input requests and classifies them into queue items.
// Depends on lfd_pkg.
module lfd_front
	import lfd_pkg::*;
(
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  logic       line_left,
	input  logic       line_mid,
	input  logic       line_right,
	input  logic [2:0] command,
	input  q_stat_t    q_stat,
	output logic       push,
	output item_t      item
);

	logic [2:0] pat;

	// Stall only on a full queue
	assign in_stall = q_stat.full;
	assign push     = in_valid & ~q_stat.full;
	assign pat      = {line_left, line_mid, line_right};

	// Classify the request by kind, pattern and command
	always_comb begin
		item.op      = OP_NOP;
		item.steer   = ST_STOP;
		item.side_wr = 1'b0;
		item.side    = SIDE_NONE;
		case (mode)
			KIND_TICK: begin
				item.op = OP_TICK;
			end
			KIND_LINE: begin
				item.op = OP_TRACE;
				case (pat)
					PAT_MID: begin
						item.steer   = ST_CENTER;
						item.side_wr = 1'b1;
						item.side    = SIDE_NONE;
					end
					PAT_RIGHT: begin
						item.steer   = ST_R_HARD;
						item.side_wr = 1'b1;
						item.side    = SIDE_RIGHT;
					end
					PAT_MID_RGT: begin
						item.steer   = ST_R_SOFT;
						item.side_wr = 1'b1;
						item.side    = SIDE_RIGHT;
					end
					PAT_LEFT: begin
						item.steer   = ST_L_HARD;
						item.side_wr = 1'b1;
						item.side    = SIDE_LEFT;
					end
					PAT_LFT_MID: begin
						item.steer   = ST_L_SOFT;
						item.side_wr = 1'b1;
						item.side    = SIDE_LEFT;
					end
					default: begin
						item.steer = ST_LOST;
					end
				endcase
			end
			KIND_CMD: begin
				case (command)
					CMD_UP: begin
						item.op    = OP_DRIVE;
						item.steer = ST_FWD;
					end
					CMD_DOWN: begin
						item.op    = OP_DRIVE;
						item.steer = ST_REV;
					end
					CMD_LEFT: begin
						item.op    = OP_DRIVE;
						item.steer = ST_LEFT;
					end
					CMD_RIGHT: begin
						item.op    = OP_DRIVE;
						item.steer = ST_RIGHT;
					end
					CMD_STOP: begin
						item.op    = OP_DRIVE;
						item.steer = ST_STOP;
					end
					CMD_MODE: begin
						item.op    = OP_MODE;
						item.steer = ST_STOP;
					end
					default: begin
						item.op = OP_NOP;
					end
				endcase
			end
			default: begin
				item.op = OP_NOP;
			end
		endcase
	end

endmodule

/* rtl/lfd_queue.sv */
// Short queue of classified items between front and back end.
// Depends on lfd_pkg.
module lfd_queue
	import lfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output q_stat_t q_stat,
	output item_t   head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	item_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;

	assign q_stat.full  = (count_q == CNT_QW'(QUEUE_DEPTH));
	assign q_stat.valid = (count_q != '0);
	assign head         = slot_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/lfd_back.sv */
// Back end: executes queued items on the drive state and holds the result.
// Depends on lfd_pkg; the result registers are the drive state itself.
module lfd_back
	import lfd_pkg::*;
#(
	parameter int PWM_PERIOD = PWM_PERIOD_DEF,
	parameter int DUTY_LIMIT = DUTY_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  q_stat_t               q_stat,
	input  item_t                 head,
	output logic                  pop,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  pwm_left,
	output logic                  pwm_right,
	output logic [1:0]            dir_left,
	output logic [1:0]            dir_right,
	output logic [DUTY_OUT_W-1:0] duty_left,
	output logic [DUTY_OUT_W-1:0] duty_right,
	output logic [1:0]            drive_state
);

	// Configuration
	logic [BASE_W-1:0]        base_q;
	logic signed [TRIM_W-1:0] trim_q;

	// Drive state
	logic [CNT_W-1:0] count_q;
	wheel_t           wl_q;
	wheel_t           wr_q;
	logic             pin_l_q;
	logic             pin_r_q;
	drive_t           mode_q;
	side_t            side_q;
	logic             out_valid_q;

	// Next state
	logic [CNT_W-1:0] count_d;
	wheel_t           wl_d;
	wheel_t           wr_d;
	logic             pin_l_d;
	logic             pin_r_d;
	drive_t           mode_d;
	side_t            side_d;

	// Speed path
	logic [CNT_W-1:0]        count_inc;
	steer_t                  steer;
	logic signed [SPD_W-1:0] co;
	logic signed [SPD_W-1:0] dif;
	logic                    neg;
	logic                    zero;
	logic signed [SPD_W-1:0] b_ext;
	logic signed [SPD_W-1:0] t_ext;
	logic signed [SPD_W-1:0] spd_l;
	logic signed [SPD_W-1:0] spd_r;
	logic signed [SPD_W-1:0] raw_l;
	logic signed [SPD_W-1:0] raw_r;
	logic                    apply;

	// Map a signed speed to direction and saturated duty
	function automatic wheel_t drive_wheel(input logic signed [SPD_W-1:0] spd);
		wheel_t           w;
		logic [SPD_W-1:0] mag;
		if (spd > 0) begin
			w.dir = DIR_FWD;
			mag   = spd;
		end else if (spd < 0) begin
			w.dir = DIR_REV;
			mag   = -spd;
		end else begin
			w.dir = DIR_STOP;
			mag   = '0;
		end
		w.duty = (mag >= SPD_W'(DUTY_LIMIT)) ? CNT_W'(DUTY_LIMIT) : mag[CNT_W-1:0];
		return w;
	endfunction

	assign pop = q_stat.valid & (~out_valid_q | ~out_stall);

	// Resolve a lost line from the remembered side
	always_comb begin
		steer = head.steer;
		if (head.steer == ST_LOST) begin
			case (side_q)
				SIDE_RIGHT: steer = ST_R_HARD;
				SIDE_LEFT:  steer = ST_L_HARD;
				default:    steer = ST_FWD;
			endcase
		end
	end

	// Common and differential offsets of each steering choice
	always_comb begin
		co   = '0;
		dif  = '0;
		neg  = 1'b0;
		zero = 1'b0;
		case (steer)
			ST_FWD:    dif = '0;
			ST_REV:    neg = 1'b1;
			ST_LEFT:   dif = -SPD_W'(OFS_TURN);
			ST_RIGHT:  dif = SPD_W'(OFS_TURN);
			ST_STOP:   zero = 1'b1;
			ST_CENTER: co = -SPD_W'(OFS_TRACE);
			ST_R_HARD: begin
				co  = -SPD_W'(OFS_TRACE);
				dif = SPD_W'(OFS_HARD_R);
			end
			ST_R_SOFT: begin
				co  = -SPD_W'(OFS_TRACE);
				dif = SPD_W'(OFS_SOFT);
			end
			ST_L_HARD: begin
				co  = -SPD_W'(OFS_TRACE);
				dif = -SPD_W'(OFS_HARD_L);
			end
			ST_L_SOFT: begin
				co  = -SPD_W'(OFS_TRACE);
				dif = -SPD_W'(OFS_SOFT);
			end
			default:   zero = 1'b1;
		endcase
	end

	// Wheel speeds: left gets minus trim, right plus trim
	assign b_ext = SPD_W'($signed({1'b0, base_q}));
	assign t_ext = SPD_W'(trim_q);
	assign raw_l = b_ext + co - t_ext + dif;
	assign raw_r = b_ext + co + t_ext - dif;
	assign spd_l = zero ? '0 : (neg ? -raw_l : raw_l);
	assign spd_r = zero ? '0 : (neg ? -raw_r : raw_r);

	assign count_inc = count_q + 1'b1;

	// Apply the head item to the drive state
	always_comb begin
		count_d = count_q;
		wl_d    = wl_q;
		wr_d    = wr_q;
		pin_l_d = pin_l_q;
		pin_r_d = pin_r_q;
		mode_d  = mode_q;
		side_d  = side_q;
		apply   = 1'b0;
		case (head.op)
			OP_TICK: begin
				count_d = count_inc;
				if (count_inc == wl_q.duty) begin
					pin_l_d = 1'b0;
				end else if (count_inc == wr_q.duty) begin
					pin_r_d = 1'b0;
				end else if (count_inc >= CNT_W'(PWM_PERIOD)) begin
					pin_l_d = 1'b1;
					pin_r_d = 1'b1;
					count_d = '0;
				end
			end
			OP_DRIVE: begin
				apply = (mode_q == DRV_MANUAL);
			end
			OP_TRACE: begin
				apply = (mode_q == DRV_TRACE);
				if (apply && head.side_wr) begin
					side_d = head.side;
				end
			end
			OP_MODE: begin
				apply = 1'b1;
				case (mode_q)
					DRV_MANUAL: mode_d = DRV_TRACE;
					DRV_TRACE:  mode_d = DRV_AVOID;
					default:    mode_d = DRV_MANUAL;
				endcase
			end
			default: begin
				apply = 1'b0;
			end
		endcase
		if (apply) begin
			wl_d = drive_wheel(spd_l);
			wr_d = drive_wheel(spd_r);
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			trim_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_SPEED: base_q <= cfg_data[BASE_W-1:0];
				REG_WHEEL_TRIM: trim_q <= cfg_data[TRIM_W-1:0];
				default:        base_q <= base_q;
			endcase
		end
	end

	// Update state on pop; hold the result while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			wl_q        <= '{dir: DIR_STOP, duty: '0};
			wr_q        <= '{dir: DIR_STOP, duty: '0};
			pin_l_q     <= 1'b0;
			pin_r_q     <= 1'b0;
			mode_q      <= DRV_MANUAL;
			side_q      <= SIDE_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				count_q     <= count_d;
				wl_q        <= wl_d;
				wr_q        <= wr_d;
				pin_l_q     <= pin_l_d;
				pin_r_q     <= pin_r_d;
				mode_q      <= mode_d;
				side_q      <= side_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pwm_left    = pin_l_q;
	assign pwm_right   = pin_r_q;
	assign dir_left    = wl_q.dir;
	assign dir_right   = wr_q.dir;
	assign duty_left   = wl_q.duty[DUTY_OUT_W-1:0];
	assign duty_right  = wr_q.duty[DUTY_OUT_W-1:0];
	assign drive_state = mode_q;

endmodule

/* rtl/lfd_checker.sv */
// Port-level checker for the line follower drive controller, bound to the top.
// Depends on lfd_pkg and line_follow_drive_pwm_top_macros.svh.
`include "line_follow_drive_pwm_top_macros.svh"

module lfd_checker
	import lfd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  pwm_left,
	input logic                  pwm_right,
	input logic [1:0]            dir_left,
	input logic [1:0]            dir_right,
	input logic [DUTY_OUT_W-1:0] duty_left,
	input logic [DUTY_OUT_W-1:0] duty_right,
	input logic [1:0]            drive_state
);

	// Hold a stalled result
	`LFD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(duty_left) && $stable(duty_right) && $stable(drive_state), "stalled result changed")

	// A stopped wheel has zero duty and a moving one has not
	`LFD_ASSERT_IMPL(a_stop_duty, clk, arst_n, 1'b1, (dir_left == DIR_STOP) == (duty_left == '0) && (dir_right == DIR_STOP) == (duty_right == '0), "direction and duty disagree")

	// A mode change stops both wheels
	`LFD_ASSERT_IMPL(a_mode_stop, clk, arst_n, !$stable(drive_state), dir_left == DIR_STOP && dir_right == DIR_STOP, "mode change left a wheel moving")

	// Both pins rise together at the period end
	`LFD_ASSERT_IMPL(a_pin_rise, clk, arst_n, $rose(pwm_left), pwm_right, "left pin rose without right pin")

	// An empty output never coincides with a stalled input
	`LFD_ASSERT_IMPL(a_no_deadlock, clk, arst_n, !out_valid, !in_stall, "input stalled with no result pending")

endmodule

bind line_follow_drive_pwm_top lfd_checker u_lfd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pwm_left    (pwm_left),
	.pwm_right   (pwm_right),
	.dir_left    (dir_left),
	.dir_right   (dir_right),
	.duty_left   (duty_left),
	.duty_right  (duty_right),
	.drive_state (drive_state)
);

/* dv/tb_line_follow_drive_pwm_top.sv */
// Testbench for line_follow_drive_pwm_top: random and directed requests with a local predictor.
// Depends on lfd_pkg and the line_follow_drive_pwm_top RTL; self-checking, no external files.
module tb_line_follow_drive_pwm_top;
	import lfd_pkg::*;

	localparam logic [1:0] KIND_SPARE      = 2'd3;
	localparam logic [2:0] CMD_UNUSED_LO   = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HI   = 3'd7;
	localparam int         HOLD_CYCLES     = 120;
	localparam int         CYCLE_LIMIT     = 300000;
	localparam int         IDLE_PCT        = 31;
	localparam int         MAX_REPORTS     = 10;

	typedef struct {
		logic [1:0] kind;
		logic       l;
		logic       m;
		logic       r;
		logic [2:0] cmd;
	} drive_request_t;

	typedef struct {
		logic                  pwm_l;
		logic                  pwm_r;
		dir_t                  dir_l;
		dir_t                  dir_r;
		logic [DUTY_OUT_W-1:0] duty_l;
		logic [DUTY_OUT_W-1:0] duty_r;
		drive_t                drv;
	} drive_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            mode = KIND_TICK;
	logic                  line_left = 1'b0;
	logic                  line_mid = 1'b0;
	logic                  line_right = 1'b0;
	logic [2:0]            command = CMD_UP;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  pwm_left;
	logic                  pwm_right;
	logic [1:0]            dir_left;
	logic [1:0]            dir_right;
	logic [DUTY_OUT_W-1:0] duty_left;
	logic [DUTY_OUT_W-1:0] duty_right;
	logic [1:0]            drive_state;
	logic                  cfg_we = 1'b0;
	logic                  cfg_index = REG_BASE_SPEED;
	logic [CFG_W-1:0]      cfg_data = '0;

	// Request and expectation stores
	drive_request_t pending_requests[$];
	drive_result_t  expected_outputs[$];

	// Predicted state of the controller
	logic [BASE_W-1:0]        cfg_base = BASE_RESET;
	logic signed [TRIM_W-1:0] cfg_trim = '0;
	logic [CNT_W-1:0]         period_ticks = '0;
	wheel_t                   left_w = '{dir: DIR_STOP, duty: '0};
	wheel_t                   right_w = '{dir: DIR_STOP, duty: '0};
	logic                     pin_l = 1'b0;
	logic                     pin_r = 1'b0;
	drive_t                   drv = DRV_MANUAL;
	side_t                    last_seen = SIDE_NONE;

	// Stimulus controls
	drive_t planned_mode = DRV_MANUAL;
	int     send_idle_pct = IDLE_PCT;
	int     recv_stall_pct = IDLE_PCT;
	logic   hold_request = 1'b0;
	logic   receiver_hold_on = 1'b0;
	int     mismatch_count = 0;
	int     cycle_count = 0;

	line_follow_drive_pwm_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.line_left(line_left),
		.line_mid(line_mid),
		.line_right(line_right),
		.command(command),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pwm_left(pwm_left),
		.pwm_right(pwm_right),
		.dir_left(dir_left),
		.dir_right(dir_right),
		.duty_left(duty_left),
		.duty_right(duty_right),
		.drive_state(drive_state),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic drive_t next_drive(input drive_t cur);
		case (cur)
			DRV_MANUAL: return DRV_TRACE;
			DRV_TRACE:  return DRV_AVOID;
			default:    return DRV_MANUAL;
		endcase
	endfunction

	// Map a signed speed to direction and saturated magnitude
	function automatic wheel_t wheel_for(input int speed);
		wheel_t w;
		int     mag;
		if (speed > 0) begin
			w.dir = DIR_FWD;
			mag = speed;
		end else if (speed < 0) begin
			w.dir = DIR_REV;
			mag = -speed;
		end else begin
			w.dir = DIR_STOP;
			mag = 0;
		end
		w.duty = (mag >= DUTY_LIMIT_DEF) ? CNT_W'(DUTY_LIMIT_DEF) : CNT_W'(mag);
		return w;
	endfunction

	task automatic set_wheels(input int l_speed, input int r_speed);
		left_w = wheel_for(l_speed);
		right_w = wheel_for(r_speed);
	endtask

	// Apply one accepted request to the predicted state and queue the outputs it yields
	task automatic advance_drive(input drive_request_t rq);
		int            b;
		int            t;
		int            c;
		logic          manual;
		drive_result_t outcome;
		b = cfg_base;
		t = cfg_trim;
		c = b - OFS_TRACE;
		manual = (drv == DRV_MANUAL);
		case (rq.kind)
			KIND_TICK: begin
				period_ticks = period_ticks + 1'b1;
				if (period_ticks == left_w.duty)
					pin_l = 1'b0;
				else if (period_ticks == right_w.duty)
					pin_r = 1'b0;
				else if (period_ticks >= PWM_PERIOD_DEF) begin
					pin_l = 1'b1;
					pin_r = 1'b1;
					period_ticks = '0;
				end
			end
			KIND_LINE: if (drv == DRV_TRACE) begin
				case ({rq.l, rq.m, rq.r})
					PAT_MID: begin
						set_wheels(c - t, c + t);
						last_seen = SIDE_NONE;
					end
					PAT_RIGHT: begin
						set_wheels(c - t + OFS_HARD_R, c + t - OFS_HARD_R);
						last_seen = SIDE_RIGHT;
					end
					PAT_MID_RGT: begin
						set_wheels(c - t + OFS_SOFT, c + t - OFS_SOFT);
						last_seen = SIDE_RIGHT;
					end
					PAT_LEFT: begin
						set_wheels(c - t - OFS_HARD_L, c + t + OFS_HARD_L);
						last_seen = SIDE_LEFT;
					end
					PAT_LFT_MID: begin
						set_wheels(c - t - OFS_SOFT, c + t + OFS_SOFT);
						last_seen = SIDE_LEFT;
					end
					default: begin
						// Line lost: steer toward the side seen last
						if (last_seen == SIDE_RIGHT)
							set_wheels(c - t + OFS_HARD_R, c + t - OFS_HARD_R);
						else if (last_seen == SIDE_LEFT)
							set_wheels(c - t - OFS_HARD_L, c + t + OFS_HARD_L);
						else
							set_wheels(b - t, b + t);
					end
				endcase
			end
			KIND_CMD: begin
				case (rq.cmd)
					CMD_UP:    if (manual) set_wheels(b - t, b + t);
					CMD_DOWN:  if (manual) set_wheels(-(b - t), -(b + t));
					CMD_LEFT:  if (manual) set_wheels(b - t - OFS_TURN, b + t + OFS_TURN);
					CMD_RIGHT: if (manual) set_wheels(b - t + OFS_TURN, b + t - OFS_TURN);
					CMD_STOP:  if (manual) set_wheels(0, 0);
					CMD_MODE: begin
						drv = next_drive(drv);
						set_wheels(0, 0);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		outcome.pwm_l = pin_l;
		outcome.pwm_r = pin_r;
		outcome.dir_l = left_w.dir;
		outcome.dir_r = right_w.dir;
		outcome.duty_l = left_w.duty[DUTY_OUT_W-1:0];
		outcome.duty_r = right_w.duty[DUTY_OUT_W-1:0];
		outcome.drv = drv;
		expected_outputs.push_back(outcome);
	endtask

	task automatic flag_error(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch: %s", what);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want)
			flag_error($sformatf("%s expected %0d got %0d", name, want, got));
	endtask

	// Offer requests; hold payload while stalled, predict on acceptance
	always @(posedge clk or negedge arst_n) begin : request_driver
		drive_request_t rq;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				rq = '{kind: mode, l: line_left, m: line_mid, r: line_right, cmd: command};
				advance_drive(rq);
			end
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					rq = pending_requests.pop_front();
					in_valid <= 1'b1;
					mode <= rq.kind;
					line_left <= rq.l;
					line_mid <= rq.m;
					line_right <= rq.r;
					command <= rq.cmd;
				end else begin
					in_valid <= 1'b0;
					mode <= 2'($urandom_range(3));
					line_left <= 1'($urandom_range(1));
					line_mid <= 1'($urandom_range(1));
					line_right <= 1'($urandom_range(1));
					command <= 3'($urandom_range(7));
				end
			end
		end
	end

	// Check accepted results against the oldest expectation, then pick the next stall
	always @(posedge clk or negedge arst_n) begin : result_monitor
		drive_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_outputs.size() == 0) begin
					flag_error("result with no request outstanding");
				end else begin
					want = expected_outputs.pop_front();
					check_field("pwm_left", want.pwm_l, pwm_left);
					check_field("pwm_right", want.pwm_r, pwm_right);
					check_field("dir_left", want.dir_l, dir_left);
					check_field("dir_right", want.dir_r, dir_right);
					check_field("duty_left", want.duty_l, duty_left);
					check_field("duty_right", want.duty_r, duty_right);
					check_field("drive_state", want.drv, drive_state);
				end
			end
			out_stall <= receiver_hold_on || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Hold off the receiver for a long stretch once asked
	initial begin : receiver_hold
		while (!hold_request) @(posedge clk);
		receiver_hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		receiver_hold_on <= 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("line_follow_drive_pwm_top test failed");
			$finish;
		end
	end

	task automatic push_request(input logic [1:0] kind, input logic l, input logic m,
			input logic r, input logic [2:0] cmd);
		drive_request_t rq;
		rq = '{kind: kind, l: l, m: m, r: r, cmd: cmd};
		if (kind == KIND_CMD && cmd == CMD_MODE)
			planned_mode = next_drive(planned_mode);
		pending_requests.push_back(rq);
	endtask

	// Wait until every request is accepted and every result has arrived
	task automatic drain_all();
		do @(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_outputs.size() != 0);
	endtask

	task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input int base, input int trim);
		drain_all();
		write_register(REG_BASE_SPEED, CFG_W'(base));
		write_register(REG_WHEEL_TRIM, CFG_W'(trim));
		cfg_base = BASE_W'(base);
		cfg_trim = TRIM_W'(trim);
	endtask

	// Queue control requests, each after a short run of ticks; favor what the mode acts on
	task automatic queue_random(input int count);
		int line_pct;
		int cmd_pct;
		int mode_pct;
		int roll;
		for (int i = 0; i < count; i++) begin
			repeat ($urandom_range(10))
				push_request(KIND_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 3'($urandom_range(7)));
			line_pct = (planned_mode == DRV_TRACE) ? 60 : 10;
			cmd_pct = (planned_mode == DRV_MANUAL) ? 55 : 10;
			mode_pct = (planned_mode == DRV_AVOID) ? 40 : 12;
			roll = $urandom_range(99);
			if (roll < line_pct)
				push_request(KIND_LINE, 1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 3'($urandom_range(7)));
			else if (roll < line_pct + cmd_pct)
				push_request(KIND_CMD, 1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 3'($urandom_range(CMD_STOP)));
			else if (roll < line_pct + cmd_pct + mode_pct)
				push_request(KIND_CMD, 1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)), CMD_MODE);
			else if ($urandom_range(1))
				push_request(KIND_CMD, 1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)), $urandom_range(1) ? CMD_UNUSED_LO : CMD_UNUSED_HI);
			else
				push_request(KIND_SPARE, 1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 3'($urandom_range(7)));
		end
	endtask

	initial begin : stimulus
		while (!arst_n) @(posedge clk);

		// Directed: reset state, every command in manual, ignored codes and kinds
		push_request(KIND_SPARE, 1'b1, 1'b1, 1'b1, CMD_UNUSED_HI);
		push_request(KIND_TICK, 1'b0, 1'b0, 1'b0, CMD_UP);
		push_request(KIND_CMD, 1'b0, 1'b0, 1'b0, CMD_UP);
		push_request(KIND_CMD, 1'b0, 1'b0, 1'b0, CMD_DOWN);
		push_request(KIND_CMD, 1'b0, 1'b0, 1'b0, CMD_LEFT);
		push_request(KIND_CMD, 1'b0, 1'b0, 1'b0, CMD_RIGHT);
		push_request(KIND_CMD, 1'b0, 1'b0, 1'b0, CMD_STOP);
		push_request(KIND_CMD, 1'b0, 1'b0, 1'b0, CMD_UNUSED_LO);
		push_request(KIND_CMD, 1'b1, 1'b1, 1'b1, CMD_UNUSED_HI);
		push_request(KIND_LINE, 1'b0, 1'b1, 1'b0, CMD_UP);
		// Trace: every pattern, line lost with each remembered side
		push_request(KIND_CMD, 1'b0, 1'b0, 1'b0, CMD_MODE);
		push_request(KIND_CMD, 1'b0, 1'b0, 1'b0, CMD_UP);
		push_request(KIND_LINE, 1'b0, 1'b0, 1'b0, CMD_UP);
		push_request(KIND_LINE, 1'b0, 1'b1, 1'b0, CMD_UP);
		push_request(KIND_LINE, 1'b0, 1'b0, 1'b1, CMD_UP);
		push_request(KIND_LINE, 1'b0, 1'b0, 1'b0, CMD_UP);
		push_request(KIND_LINE, 1'b0, 1'b1, 1'b1, CMD_UP);
		push_request(KIND_LINE, 1'b1, 1'b0, 1'b0, CMD_UP);
		push_request(KIND_LINE, 1'b0, 1'b0, 1'b0, CMD_UP);
		push_request(KIND_LINE, 1'b1, 1'b1, 1'b0, CMD_UP);
		push_request(KIND_LINE, 1'b1, 1'b1, 1'b1, CMD_UP);
		push_request(KIND_LINE, 1'b1, 1'b0, 1'b1, CMD_UP);
		// Avoid ignores samples, then back to manual
		push_request(KIND_CMD, 1'b0, 1'b0, 1'b0, CMD_MODE);
		push_request(KIND_LINE, 1'b0, 1'b1, 1'b0, CMD_UP);
		push_request(KIND_CMD, 1'b0, 1'b0, 1'b0, CMD_MODE);

		// Full speed with saturation, equal duties and duty at the period end
		configure(1000, 0);
		queue_random(35);

		// Receiver holds off while the sender keeps offering
		configure(0, -200);
		hold_request = 1'b1;
		queue_random(35);

		// No idling on either side
		configure(1000, 200);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random(35);
		drain_all();
		send_idle_pct = IDLE_PCT;
		recv_stall_pct = IDLE_PCT;

		// Sender pauses mid-phase until all results are back
		configure(0, 200);
		queue_random(17);
		drain_all();
		queue_random(18);

		configure($urandom_range(1000), int'($urandom_range(400)) - 200);
		queue_random(35);
		configure($urandom_range(1000), int'($urandom_range(400)) - 200);
		queue_random(35);

		drain_all();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("line_follow_drive_pwm_top test passed");
		else
			$display("line_follow_drive_pwm_top test failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/lfd_pkg.sv
rtl/lfd_front.sv
rtl/lfd_queue.sv
rtl/lfd_back.sv
rtl/line_follow_drive_pwm_top.sv
rtl/lfd_checker.sv
dv/tb_line_follow_drive_pwm_top.sv
